// ===== src/matrix3x3_inverse_determinant_assert.svh =====
// assertion macros for the rtl of the 3x3 inverse block, used by the queue
// no dependencies; expects clk and rst_n in the scope of each use
`ifndef MATRIX3X3_INVERSE_DETERMINANT_ASSERT_SVH
`define MATRIX3X3_INVERSE_DETERMINANT_ASSERT_SVH
`ifndef ASSERT_OFF
`define M3INV_ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("m3inv: forbidden condition seen");
`define M3INV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("m3inv: expected follow-up did not happen");
`else
`define M3INV_ASSERT_NEVER(lbl, expr)
`define M3INV_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== src/m3inv_pkg.sv =====
// shared types for the 3x3 inverse / determinant block
// no dependencies
`timescale 1ns / 1ps

package m3inv_pkg;

    // queue status seen by the front and back parts
    typedef struct packed {
        logic not_full;
        logic not_empty;
    } fifo_stat_t;

endpackage

// ===== src/m3inv_front.sv =====
// front part: takes matrices, forms the nine cofactors and the determinant
// depends on m3inv_pkg
`timescale 1ns / 1ps

module m3inv_front
    import m3inv_pkg::*;
#(
    parameter int W = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [W-1:0]   elem [9],
    input  fifo_stat_t            stat,
    output logic                  push,
    output logic [9*(2*W+1)+3*W+3:0] push_data
);

    localparam int CW = 2 * W + 1;
    localparam int TW = 3 * W + 2;
    localparam int DW = 3 * W + 4;

    logic [5:0] v_reg;
    logic       adv;

    logic signed [W-1:0]    e_reg    [9];
    logic signed [2*W-1:0]  prod_reg [18];
    logic signed [W-1:0]    a1_reg   [3];
    logic signed [W-1:0]    a2_reg   [3];
    logic signed [CW-1:0]   cof2_reg [9];
    logic signed [CW-1:0]   cof3_reg [9];
    logic signed [CW-1:0]   cof4_reg [9];
    logic signed [CW-1:0]   cof5_reg [9];
    logic signed [CW-1:0]   pl_reg   [3];
    logic signed [CW-1:0]   ph_reg   [3];
    logic signed [TW-1:0]   term_reg [3];
    logic signed [DW-1:0]   det_reg;

    assign adv      = !v_reg[5] || stat.not_full;
    assign in_ready = adv;
    assign push     = v_reg[5] && stat.not_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    genvar gi, gj;
    generate
        for (gi = 0; gi < 9; gi++)
        begin : g_in
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    e_reg[gi]    <= elem[gi];
                    cof3_reg[gi] <= cof2_reg[gi];
                    cof4_reg[gi] <= cof3_reg[gi];
                    cof5_reg[gi] <= cof4_reg[gi];
                end
            end
        end

        for (gi = 0; gi < 3; gi++)
        begin : g_row
            for (gj = 0; gj < 3; gj++)
            begin : g_col
                localparam int R1 = (gi == 0) ? 1 : 0;
                localparam int R2 = (gi == 2) ? 1 : 2;
                localparam int C1 = (gj == 0) ? 1 : 0;
                localparam int C2 = (gj == 2) ? 1 : 2;
                localparam int K  = 3 * gi + gj;

                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        prod_reg[2*K]   <= e_reg[3*R1+C1] * e_reg[3*R2+C2];
                        prod_reg[2*K+1] <= e_reg[3*R1+C2] * e_reg[3*R2+C1];
                        // odd positions take the negated minor
                        if (((gi + gj) % 2) == 1)
                        begin
                            cof2_reg[K] <= CW'(prod_reg[2*K+1]) - CW'(prod_reg[2*K]);
                        end
                        else
                        begin
                            cof2_reg[K] <= CW'(prod_reg[2*K]) - CW'(prod_reg[2*K+1]);
                        end
                    end
                end
            end

            // first row expansion, cofactor split into low and high halves
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    a1_reg[gi]   <= e_reg[gi];
                    a2_reg[gi]   <= a1_reg[gi];
                    pl_reg[gi]   <= a2_reg[gi] * $signed({1'b0, cof2_reg[gi][W-1:0]});
                    ph_reg[gi]   <= a2_reg[gi] * $signed(cof2_reg[gi][CW-1:W]);
                    term_reg[gi] <= (TW'(ph_reg[gi]) <<< W) + TW'(pl_reg[gi]);
                end
            end
        end

        for (gi = 0; gi < 9; gi++)
        begin : g_pack
            assign push_data[gi*CW +: CW] = cof5_reg[gi];
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            det_reg <= DW'(term_reg[0]) + DW'(term_reg[1]) + DW'(term_reg[2]);
        end
    end

    assign push_data[9*CW +: DW] = det_reg;

endmodule

// ===== src/m3inv_fifo.sv =====
// two-entry queue between the front and back parts
// depends on m3inv_pkg and matrix3x3_inverse_determinant_assert.svh
`timescale 1ns / 1ps
`include "matrix3x3_inverse_determinant_assert.svh"

module m3inv_fifo
    import m3inv_pkg::*;
#(
    parameter int DATA_W = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output fifo_stat_t        stat
);

    localparam int DEPTH = 2;
    localparam int AW    = 1;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [AW-1:0]     wr_ptr_reg;
    logic [AW-1:0]     rd_ptr_reg;
    logic [AW:0]       count_reg;
    logic [AW:0]       count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data       = mem[rd_ptr_reg];
    assign stat.not_full  = (count_reg != (AW+1)'(DEPTH));
    assign stat.not_empty = (count_reg != '0);

    `M3INV_ASSERT_NEVER(a_no_overflow, push && !pop && count_reg == (AW+1)'(DEPTH))
    `M3INV_ASSERT_NEVER(a_no_underflow, pop && count_reg == '0)
    `M3INV_ASSERT_NEVER(a_count_range, count_reg > (AW+1)'(DEPTH))
    `M3INV_ASSERT_NEXT(a_push_grows, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

// ===== src/m3inv_back.sv =====
// back part: rounded restoring division of the adjugate by the determinant,
// saturation and output register; depends on m3inv_pkg
`timescale 1ns / 1ps

module m3inv_back
    import m3inv_pkg::*;
#(
    parameter int W = 32,
    parameter int F = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  fifo_stat_t            stat,
    input  logic [9*(2*W+1)+3*W+3:0] pop_data,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [W-1:0]   r [9],
    output logic signed [W-1:0]   det_out,
    output logic                  singular,
    output logic                  saturated
);

    localparam int CW  = 2 * W + 1;
    localparam int DW  = 3 * W + 4;
    localparam int QB  = W + 2;
    localparam int MW  = CW + 2 * F + 1;
    localparam int DSW = DW + QB;
    localparam int RW  = ((MW > DSW) ? MW : DSW) + 1;

    localparam logic [DW:0]   DHALF = (DW+1)'(1) << (2 * F - 1);
    localparam logic [DW:0]   DLIMP = ((DW+1)'(1) << (W - 1)) - (DW+1)'(1);
    localparam logic [DW:0]   DLIMN = (DW+1)'(1) << (W - 1);
    localparam logic [QB-1:0] QLIMP = ((QB)'(1) << (W - 1)) - (QB)'(1);
    localparam logic [QB-1:0] QLIMN = (QB)'(1) << (W - 1);
    localparam logic [W-1:0]  MAXV  = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  MINV  = {1'b1, {(W-1){1'b0}}};

    logic adv;

    // pipeline index 0 is the prep stage, 1..QB the division steps
    logic [QB:0]   v_reg;
    logic [RW-1:0] rem_reg  [QB+1][9];
    logic [QB-1:0] quo_reg  [QB+1][9];
    logic [DW-1:0] dm_reg   [QB+1];
    logic [8:0]    neg_reg  [QB+1];
    logic [8:0]    ovf_reg  [QB+1];
    logic [W-1:0]  dv_reg   [QB+1];
    logic          dsat_reg [QB+1];
    logic          sing_reg [QB+1];

    logic                 out_valid_reg;
    logic signed [W-1:0]  r_reg [9];
    logic signed [W-1:0]  det_out_reg;
    logic                 singular_reg;
    logic                 saturated_reg;

    logic signed [DW-1:0] det_in;
    logic                 dneg;
    logic [DW-1:0]        dm;
    logic [DW:0]          dr;
    logic                 dsat;
    logic [W-1:0]         dv;
    logic [8:0]           sat_lane;

    assign adv = !out_valid_reg || out_ready;
    assign pop = adv && stat.not_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg         <= {v_reg[QB-1:0], stat.not_empty};
            out_valid_reg <= v_reg[QB];
        end
    end

    // determinant magnitude and its rounded output value
    always_comb
    begin
        det_in = $signed(pop_data[9*CW +: DW]);
        dneg   = det_in[DW-1];
        dm     = dneg ? DW'(-det_in) : DW'(det_in);
        dr     = ({1'b0, dm} + DHALF) >> (2 * F);
        dsat   = dneg ? (dr > DLIMN) : (dr > DLIMP);
        if (dsat)
        begin
            dv = dneg ? MINV : MAXV;
        end
        else
        begin
            dv = dneg ? (-dr[W-1:0]) : dr[W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dm_reg[0]   <= dm;
            dv_reg[0]   <= dv;
            dsat_reg[0] <= dsat;
            sing_reg[0] <= (det_in == '0);
        end
    end

    genvar gl, gs;
    generate
        for (gl = 0; gl < 9; gl++)
        begin : g_prep
            logic signed [CW-1:0] c;
            logic [CW-1:0]        nm;
            logic [RW-1:0]        rem0;

            always_comb
            begin
                c    = $signed(pop_data[gl*CW +: CW]);
                nm   = c[CW-1] ? CW'(-c) : CW'(c);
                rem0 = RW'(nm) << (2 * F + 1);
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[0][gl] <= rem0;
                    quo_reg[0][gl] <= '0;
                    neg_reg[0][gl] <= c[CW-1] ^ dneg;
                    // quotient would not fit the step count
                    ovf_reg[0][gl] <= rem0 >= (RW'(dm) << QB);
                end
            end
        end

        for (gs = 0; gs < QB; gs++)
        begin : g_step
            localparam int K = QB - 1 - gs;

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    dm_reg[gs+1]   <= dm_reg[gs];
                    neg_reg[gs+1]  <= neg_reg[gs];
                    ovf_reg[gs+1]  <= ovf_reg[gs];
                    dv_reg[gs+1]   <= dv_reg[gs];
                    dsat_reg[gs+1] <= dsat_reg[gs];
                    sing_reg[gs+1] <= sing_reg[gs];
                end
            end

            for (gl = 0; gl < 9; gl++)
            begin : g_lane
                logic [RW-1:0] sub;
                logic          ge;

                always_comb
                begin
                    sub = RW'(dm_reg[gs]) << K;
                    ge  = rem_reg[gs][gl] >= sub;
                end

                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        rem_reg[gs+1][gl] <= ge ? (rem_reg[gs][gl] - sub) : rem_reg[gs][gl];
                        quo_reg[gs+1][gl] <= quo_reg[gs][gl] | (ge ? (QB'(1) << K) : '0);
                    end
                end
            end
        end

        // output row i column j comes from cofactor row j column i
        for (gl = 0; gl < 9; gl++)
        begin : g_out
            localparam int SRC = 3 * (gl % 3) + (gl / 3);
            logic [QB:0]   q1;
            logic [QB-1:0] mag;
            logic          ng;
            logic [W-1:0]  val;

            always_comb
            begin
                q1  = {1'b0, quo_reg[QB][SRC]} + (QB+1)'(1);
                mag = q1[QB:1];
                ng  = neg_reg[QB][SRC];
                sat_lane[gl] = ovf_reg[QB][SRC] || (ng ? (mag > QLIMN) : (mag > QLIMP));
                if (sat_lane[gl])
                begin
                    val = ng ? MINV : MAXV;
                end
                else
                begin
                    val = ng ? (-mag[W-1:0]) : mag[W-1:0];
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    r_reg[gl] <= sing_reg[QB] ? '0 : $signed(val);
                end
            end

            assign r[gl] = r_reg[gl];
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            det_out_reg   <= sing_reg[QB] ? '0 : $signed(dv_reg[QB]);
            singular_reg  <= sing_reg[QB];
            saturated_reg <= !sing_reg[QB] && ((|sat_lane) || dsat_reg[QB]);
        end
    end

    assign out_valid = out_valid_reg;
    assign det_out   = det_out_reg;
    assign singular  = singular_reg;
    assign saturated = saturated_reg;

endmodule

// ===== src/matrix3x3_inverse_determinant.sv =====
// 3x3 fixed-point matrix inverse and determinant, top level
// depends on m3inv_pkg, m3inv_front, m3inv_fifo, m3inv_back
`timescale 1ns / 1ps

// usage:
// input request: a11..a33, signed Q(ELEM_WIDTH-FRAC_BITS).FRAC_BITS, taken when
//   in_valid and in_ready are both high at a rising edge
// output request: r11..r33 (inverse), det_out, singular, saturated, handed over
//   when out_valid and out_ready are both high
// throughput: one matrix per cycle unless the receiver stalls, fully pipelined
// path: the front forms cofactors and determinant in registered stages, the
//   queue holds the result, and the back runs a prep stage, a
//   one-bit-per-stage restoring division on nine lanes in parallel and an
//   output register
// a zero determinant gives singular = 1 and all other fields zero
// reset clears all valid flags; no matrix is held across reset
// when the receiver stalls the back pipeline holds, the two-entry queue
//   fills, and then the front holds and drops in_ready
module matrix3x3_inverse_determinant
    import m3inv_pkg::*;
#(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [ELEM_WIDTH-1:0] a11,
    input  logic signed [ELEM_WIDTH-1:0] a12,
    input  logic signed [ELEM_WIDTH-1:0] a13,
    input  logic signed [ELEM_WIDTH-1:0] a21,
    input  logic signed [ELEM_WIDTH-1:0] a22,
    input  logic signed [ELEM_WIDTH-1:0] a23,
    input  logic signed [ELEM_WIDTH-1:0] a31,
    input  logic signed [ELEM_WIDTH-1:0] a32,
    input  logic signed [ELEM_WIDTH-1:0] a33,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [ELEM_WIDTH-1:0] r11,
    output logic signed [ELEM_WIDTH-1:0] r12,
    output logic signed [ELEM_WIDTH-1:0] r13,
    output logic signed [ELEM_WIDTH-1:0] r21,
    output logic signed [ELEM_WIDTH-1:0] r22,
    output logic signed [ELEM_WIDTH-1:0] r23,
    output logic signed [ELEM_WIDTH-1:0] r31,
    output logic signed [ELEM_WIDTH-1:0] r32,
    output logic signed [ELEM_WIDTH-1:0] r33,
    output logic signed [ELEM_WIDTH-1:0] det_out,
    output logic                         singular,
    output logic                         saturated
);

    localparam int QW = 9 * (2 * ELEM_WIDTH + 1) + 3 * ELEM_WIDTH + 4;

    logic signed [ELEM_WIDTH-1:0] elem [9];
    logic signed [ELEM_WIDTH-1:0] r    [9];
    logic                         push;
    logic                         pop;
    logic [QW-1:0]                push_data;
    logic [QW-1:0]                pop_data;
    fifo_stat_t                   stat;

    assign elem[0] = a11;
    assign elem[1] = a12;
    assign elem[2] = a13;
    assign elem[3] = a21;
    assign elem[4] = a22;
    assign elem[5] = a23;
    assign elem[6] = a31;
    assign elem[7] = a32;
    assign elem[8] = a33;

    m3inv_front #(
        .W (ELEM_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .elem      (elem),
        .stat      (stat),
        .push      (push),
        .push_data (push_data)
    );

    m3inv_fifo #(
        .DATA_W (QW)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (stat)
    );

    m3inv_back #(
        .W (ELEM_WIDTH),
        .F (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .stat      (stat),
        .pop_data  (pop_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .r         (r),
        .det_out   (det_out),
        .singular  (singular),
        .saturated (saturated)
    );

    assign r11 = r[0];
    assign r12 = r[1];
    assign r13 = r[2];
    assign r21 = r[3];
    assign r22 = r[4];
    assign r23 = r[5];
    assign r31 = r[6];
    assign r32 = r[7];
    assign r33 = r[8];

endmodule
